// ===== design/per_client_datagram_quota_table_macros.svh =====
// Assertion shorthands used by the quota table module.
`ifndef PER_CLIENT_DATAGRAM_QUOTA_TABLE_MACROS_SVH
`define PER_CLIENT_DATAGRAM_QUOTA_TABLE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PCDQ_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PCDQ_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== design/pcdq_pkg.sv =====
package pcdq_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam int KEY_W   = 64;
    localparam int CMP_W   = 32;
    localparam int MAXD_W  = 16;
    localparam int MAXC_W  = 5;
    localparam int CFG_IDX_W = 8;

    localparam logic [MAXD_W-1:0] RST_MAX_DATAGRAMS = MAXD_W'(16);
    localparam logic [MAXC_W-1:0] RST_MAX_CLIENTS   = MAXC_W'(16);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DATAGRAMS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CLIENTS   = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic valid;     // entry is occupied and may be compared
        logic load_new;  // take the incoming key with a count of one
        logic shift;     // take key and count from the next cell up
        logic inc;       // count one more datagram
    } t_cell_ctrl;

endpackage

// ===== design/pcdq_cell.sv =====
module pcdq_cell
    import pcdq_pkg::*;
#(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  t_cell_ctrl             i_ctrl,
    input  logic [KEY_W-1:0]       i_key,
    input  logic [KEY_W-1:0]       i_next_key,
    input  logic [COUNT_WIDTH-1:0] i_next_count,
    input  logic [MAXD_W-1:0]      i_max_datagrams,
    output logic                   o_hit,
    output logic                   o_at_max,
    output logic [KEY_W-1:0]       o_key,
    output logic [COUNT_WIDTH-1:0] o_count
);

    logic [KEY_W-1:0]       r_key;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [KEY_W-1:0]       n_key;
    logic [COUNT_WIDTH-1:0] n_count;

    always_comb begin
        n_key   = r_key;
        n_count = r_count;
        if (i_ctrl.load_new) begin
            n_key   = i_key;
            n_count = COUNT_WIDTH'(1);
        end else if (i_ctrl.shift) begin
            n_key   = i_next_key;
            n_count = i_next_count;
        end else if (i_ctrl.inc && (r_count != {COUNT_WIDTH{1'b1}})) begin
            n_count = r_count + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_count <= n_count;
    end

    assign o_hit    = i_ctrl.valid && (r_key == i_key);
    assign o_at_max = (CMP_W'(r_count) == CMP_W'(i_max_datagrams));
    assign o_key    = r_key;
    assign o_count  = r_count;

endmodule

// ===== design/per_client_datagram_quota_table.sv =====
// Channel  | Direction | Payload
// s (in)   | slave     | tdata: client_family, client_port, client_address
// m (out)  | master    | tdata: allowed
// cfg      | slave     | register index and write data
//
// Each datagram passes through accept (ST_IDLE), a parallel compare across the
// cell chain (ST_LOOKUP), then an update (ST_UPDATE) that increments, appends or
// shifts the chain. The next datagram is accepted in the cycle after the update.
// The update waits while the previous result is still held in the output
// register. Reset empties the table at once; no clearing pass is needed.
module per_client_datagram_quota_table
    import pcdq_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [15:0] client_family, [31:16] client_port, [63:32] client_address
    input  logic [KEY_W-1:0]     i_s_tdata,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [0] allowed, [7:1] zero
    output logic [7:0]           o_m_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MAXD_W-1:0]    i_cfg_data
);

    `include "per_client_datagram_quota_table_macros.svh"

    localparam int SZ_W = $clog2(TABLE_DEPTH + 1);

    t_state r_state;
    t_state n_state;

    logic [MAXD_W-1:0]      r_max_datagrams;
    logic [MAXC_W-1:0]      r_max_clients;
    logic [KEY_W-1:0]       r_key;
    logic [TABLE_DEPTH-1:0] r_hit;
    logic [SZ_W-1:0]        r_occ;
    logic [SZ_W-1:0]        n_occ;
    logic                   r_out_valid;
    logic                   r_allowed;

    logic [TABLE_DEPTH-1:0] cell_hit;
    logic [TABLE_DEPTH-1:0] cell_at_max;
    logic [KEY_W-1:0]       cell_key   [TABLE_DEPTH];
    logic [COUNT_WIDTH-1:0] cell_count [TABLE_DEPTH];
    t_cell_ctrl             cell_ctrl  [TABLE_DEPTH];

    logic            s_accept;
    logic            upd_go;
    logic            miss;
    logic            full;
    logic [SZ_W-1:0] size;
    logic [SZ_W-1:0] size_m1;

    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;

    // Table size clamped to one through the table depth.
    always_comb begin
        if (r_max_clients == '0) begin
            size = SZ_W'(1);
        end else if (CMP_W'(r_max_clients) > CMP_W'(TABLE_DEPTH)) begin
            size = SZ_W'(TABLE_DEPTH);
        end else begin
            size = SZ_W'(r_max_clients);
        end
    end

    assign size_m1 = size - SZ_W'(1);
    assign miss    = ~|r_hit;
    assign full    = (r_occ >= size);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        upd_go     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_LOOKUP: begin
                upd_go = 1'b0;
            end
            ST_UPDATE: begin
                upd_go = !r_out_valid || i_m_tready;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_occ = r_occ;
        if (upd_go && miss) begin
            n_occ = full ? size : (r_occ + SZ_W'(1));
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        localparam logic [SZ_W-1:0] IDX = SZ_W'(g);

        always_comb begin
            cell_ctrl[g].valid    = (IDX < r_occ);
            cell_ctrl[g].load_new = upd_go && miss && (full ? (IDX == size_m1) : (IDX == r_occ));
            cell_ctrl[g].shift    = upd_go && miss && full && (IDX < size_m1);
            cell_ctrl[g].inc      = upd_go && r_hit[g] && !cell_at_max[g];
        end

        // The top cell never shifts; it is wired to itself.
        if (g == TABLE_DEPTH - 1) begin : g_top
            pcdq_cell #(
                .COUNT_WIDTH(COUNT_WIDTH)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctrl         (cell_ctrl[g]),
                .i_key          (r_key),
                .i_next_key     (cell_key[g]),
                .i_next_count   (cell_count[g]),
                .i_max_datagrams(r_max_datagrams),
                .o_hit          (cell_hit[g]),
                .o_at_max       (cell_at_max[g]),
                .o_key          (cell_key[g]),
                .o_count        (cell_count[g])
            );
        end else begin : g_mid
            pcdq_cell #(
                .COUNT_WIDTH(COUNT_WIDTH)
            ) u_cell (
                .i_clk          (i_clk),
                .i_ctrl         (cell_ctrl[g]),
                .i_key          (r_key),
                .i_next_key     (cell_key[g+1]),
                .i_next_count   (cell_count[g+1]),
                .i_max_datagrams(r_max_datagrams),
                .o_hit          (cell_hit[g]),
                .o_at_max       (cell_at_max[g]),
                .o_key          (cell_key[g]),
                .o_count        (cell_count[g])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_max_datagrams <= RST_MAX_DATAGRAMS;
            r_max_clients   <= RST_MAX_CLIENTS;
            r_occ           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MAX_DATAGRAMS) begin
                    r_max_datagrams <= i_cfg_data;
                end else if (i_cfg_index == CFG_MAX_CLIENTS) begin
                    r_max_clients <= i_cfg_data[MAXC_W-1:0];
                end
            end
            if (upd_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_key <= i_s_tdata;
        end
        if (r_state == ST_LOOKUP) begin
            r_hit <= cell_hit;
        end
        if (upd_go) begin
            // A source is refused only when its count sits exactly at the quota.
            r_allowed <= ~|(r_hit & cell_at_max);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'b0, r_allowed};

    `PCDQ_ASSERT_SAME(a_occ_bound, 1'b1, CMP_W'(r_occ) <= CMP_W'(TABLE_DEPTH), "occupancy beyond table depth")
    `PCDQ_ASSERT_SAME(a_single_hit, r_state == ST_UPDATE, $onehot0(r_hit), "more than one entry matched")
    `PCDQ_ASSERT_NEXT(a_result_out, upd_go, o_m_tvalid, "result lost after update")
    `PCDQ_ASSERT_NEXT(a_miss_fills, upd_go && miss, r_occ != '0, "table empty after insertion")

endmodule
